[src/cbm_pkg.sv]
package cbm_pkg;

  localparam int unsigned AddrW     = 16;
  localparam int unsigned DataW     = 8;
  localparam int unsigned RomAddrW  = 23;
  localparam int unsigned RamAddrW  = 17;
  localparam int unsigned RomBytesW = 24;
  localparam int unsigned CtrlW     = 3;
  localparam int unsigned TargetW   = 3;
  localparam int unsigned CfgDataW  = 24;
  localparam int unsigned CfgIdxW   = 1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgCtrlType = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgRomBytes = 1'd1;

  localparam logic [RomBytesW-1:0] RomBytesReset = 24'h008000;

  typedef enum logic [TargetW-1:0] {
    TGT_ROM_READ  = 3'd0,
    TGT_RAM_READ  = 3'd1,
    TGT_RAM_WRITE = 3'd2,
    TGT_OPEN_BUS  = 3'd3,
    TGT_CONTROL   = 3'd4,
    TGT_NOT_CART  = 3'd5
  } target_e;

  localparam logic [CtrlW-1:0] CtrlRomOnly = 3'd0;
  localparam logic [CtrlW-1:0] CtrlMbc1    = 3'd1;
  localparam logic [CtrlW-1:0] CtrlMbc2    = 3'd2;
  localparam logic [CtrlW-1:0] CtrlMbc3    = 3'd3;
  localparam logic [CtrlW-1:0] CtrlMbc5    = 3'd4;

  // Bus access kind
  localparam logic FuncRead  = 1'b0;
  localparam logic FuncWrite = 1'b1;

  // Control window inside 0x0000-0x7FFF, from address bits 14:13
  localparam logic [1:0] WinRamEnable = 2'd0;
  localparam logic [1:0] WinRomBank   = 2'd1;
  localparam logic [1:0] WinRamBank   = 2'd2;
  localparam logic [1:0] WinMode      = 2'd3;

  // Cartridge RAM window 0xA000-0xBFFF, address bits 15:13
  localparam logic [2:0] RamWindowTop = 3'b101;

  localparam logic [3:0] RamEnableKey = 4'hA;

endpackage

[src/cbm_req_if.sv]
interface cbm_req_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [15:0] bus_address;
  logic [7:0]  write_byte;

  modport source (output valid, output func, output bus_address, output write_byte,
                  input ready);
  modport sink   (input valid, input func, input bus_address, input write_byte,
                  output ready);
endinterface

[src/cbm_rsp_if.sv]
interface cbm_rsp_if import cbm_pkg::*; ();
  logic                valid;
  logic                ready;
  target_e             target;
  logic [RomAddrW-1:0] rom_address;
  logic [RamAddrW-1:0] ram_address;
  logic [DataW-1:0]    ram_data;
  logic                force_high_nibble;

  modport source (output valid, output target, output rom_address, output ram_address,
                  output ram_data, output force_high_nibble, input ready);
  modport sink   (input valid, input target, input rom_address, input ram_address,
                  input ram_data, input force_high_nibble, output ready);
endinterface

[src/cartridge_bank_mapper_core.sv]
// Channel   | Dir | Handshake     | Payload
// req_i     | in  | valid/ready   | func, bus_address, write_byte
// rsp_o     | out | valid/ready   | target, rom_address, ram_address, ram_data,
//           |     |               | force_high_nibble
// cfg       | in  | cfg_we_i      | cfg_idx_i, cfg_data_i (no read-back)
//
// One transaction per cycle while no result is stalled: the access is translated in the cycle it is
// accepted and its result sits in the output register from the next cycle.
// Bank register writes land on the same edge, so the next transaction sees them.
// Reset (rst_ni low, asynchronous) clears the output valid and loads the
// controller and bank registers with their power-on values.
// A stalled result holds in the output register and holds req_i.ready low.
module cartridge_bank_mapper_core
  import cbm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  cbm_req_if.sink             req_i,
  cbm_rsp_if.source           rsp_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // Configuration
  logic [CtrlW-1:0]     ctrl_type_q;
  logic [RomBytesW-1:0] rom_bytes_q;

  // Bank controller state
  logic       ram_en_q,         ram_en_d;
  logic [4:0] mbc1_low_q,       mbc1_low_d;
  logic [1:0] mbc1_high_q,      mbc1_high_d;
  logic       mbc1_ram_mode_q,  mbc1_ram_mode_d;
  logic [8:0] rom_bank_q,       rom_bank_d;
  logic [8:0] mbc5_bank_q,      mbc5_bank_d;
  logic [3:0] ram_bank_q,       ram_bank_d;

  // Output register
  logic                rsp_valid_q;
  target_e             target_q,   target_d;
  logic [RomAddrW-1:0] rom_addr_q, rom_addr_d;
  logic [RamAddrW-1:0] ram_addr_q, ram_addr_d;
  logic [DataW-1:0]    ram_data_q, ram_data_d;
  logic                high_nib_q, high_nib_d;

  logic accept;
  logic is_write;
  logic [AddrW-1:0] addr;
  logic [DataW-1:0] data;
  logic [1:0] win;
  logic [RomAddrW-1:0] mapped;
  logic is_mbc2;
  logic [4:0] low_v;
  logic [3:0] mbc2_v;
  logic [6:0] mbc3_v;
  logic enable_v;

  // Hold the result while the sink stalls; otherwise take a new transaction
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  assign is_write = (req_i.func == FuncWrite);
  assign addr     = req_i.bus_address;
  assign data     = req_i.write_byte;
  assign win      = addr[14:13];
  assign is_mbc2  = (ctrl_type_q == CtrlMbc2);
  assign enable_v = (data[3:0] == RamEnableKey);
  assign low_v    = data[4:0];
  assign mbc2_v   = data[3:0];
  assign mbc3_v   = data[6:0];

  // Physical ROM address of a read in 0x0000-0x7FFF. The fixed area maps
  // to bank high_bits<<5 only for MBC1 in RAM-banking mode.
  always_comb begin
    if (!addr[14]) begin
      if ((ctrl_type_q == CtrlMbc1) && mbc1_ram_mode_q) begin
        mapped = {2'b00, mbc1_high_q, 5'b00000, addr[13:0]};
      end else begin
        mapped = {9'd0, addr[13:0]};
      end
    end else begin
      mapped = {rom_bank_q, addr[13:0]};
    end
  end

  // Control writes into the bank registers
  always_comb begin
    ram_en_d        = ram_en_q;
    mbc1_low_d      = mbc1_low_q;
    mbc1_high_d     = mbc1_high_q;
    mbc1_ram_mode_d = mbc1_ram_mode_q;
    rom_bank_d      = rom_bank_q;
    mbc5_bank_d     = mbc5_bank_q;
    ram_bank_d      = ram_bank_q;
    if (accept && is_write && !addr[15]) begin
      case (ctrl_type_q)
        CtrlMbc1: begin
          case (win)
            WinRamEnable: ram_en_d        = enable_v;
            WinRomBank:   mbc1_low_d      = (low_v == 5'd0) ? 5'd1 : low_v;
            WinRamBank:   mbc1_high_d     = data[1:0];
            WinMode:      mbc1_ram_mode_d = data[0];
            default:      ram_en_d        = ram_en_q;
          endcase
          // Remap after every MBC1 bank or mode register write
          if (win != WinRamEnable) begin
            rom_bank_d = {2'b00, mbc1_high_d, mbc1_low_d};
            ram_bank_d = mbc1_ram_mode_d ? {2'b00, mbc1_high_d} : 4'd0;
          end
        end
        CtrlMbc2: begin
          // 0x0000-0x3FFF decoded by address bit 8
          if (!addr[14]) begin
            if (!addr[8]) begin
              ram_en_d = enable_v;
            end else begin
              rom_bank_d = {5'd0, (mbc2_v == 4'd0) ? 4'd1 : mbc2_v};
            end
          end
        end
        CtrlMbc3: begin
          case (win)
            WinRamEnable: ram_en_d = enable_v;
            WinRomBank:   rom_bank_d = {2'b00, (mbc3_v == 7'd0) ? 7'd1 : mbc3_v};
            WinRamBank: begin
              // Values above 3 select clock registers, not RAM: drop them
              if (data <= 8'd3) begin
                ram_bank_d = data[3:0];
              end
            end
            default: ram_en_d = ram_en_q;
          endcase
        end
        CtrlMbc5: begin
          case (win)
            WinRamEnable: ram_en_d = enable_v;
            WinRomBank: begin
              if (!addr[12]) begin
                mbc5_bank_d = {mbc5_bank_q[8], data};
              end else begin
                mbc5_bank_d = {data[0], mbc5_bank_q[7:0]};
              end
              rom_bank_d = mbc5_bank_d;
            end
            WinRamBank: ram_bank_d = data[3:0];
            default:    ram_en_d = ram_en_q;
          endcase
        end
        default: ram_en_d = ram_en_q;  // ROM only and unused codes
      endcase
    end
  end

  // Translate the access using the state before this transaction's write
  always_comb begin
    target_d   = TGT_NOT_CART;
    rom_addr_d = '0;
    ram_addr_d = '0;
    ram_data_d = '0;
    high_nib_d = 1'b0;
    if (!addr[15]) begin
      if (is_write) begin
        target_d = TGT_CONTROL;
      end else if ({1'b0, mapped} < rom_bytes_q) begin
        target_d   = TGT_ROM_READ;
        rom_addr_d = mapped;
      end else begin
        target_d = TGT_OPEN_BUS;
      end
    end else if (addr[15:13] == RamWindowTop) begin
      if (!ram_en_q) begin
        target_d = is_write ? TGT_CONTROL : TGT_OPEN_BUS;
      end else begin
        // MBC2 has 512 nibbles of built-in RAM
        ram_addr_d = is_mbc2 ? {8'd0, addr[8:0]} : {ram_bank_q, addr[12:0]};
        if (is_write) begin
          target_d   = TGT_RAM_WRITE;
          ram_data_d = is_mbc2 ? {4'h0, data[3:0]} : data;
        end else begin
          target_d   = TGT_RAM_READ;
          high_nib_d = is_mbc2;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_type_q <= CtrlRomOnly;
      rom_bytes_q <= RomBytesReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgCtrlType: ctrl_type_q <= cfg_data_i[CtrlW-1:0];
        CfgRomBytes: rom_bytes_q <= cfg_data_i[RomBytesW-1:0];
        default:     rom_bytes_q <= rom_bytes_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ram_en_q        <= 1'b0;
      mbc1_low_q      <= 5'd1;
      mbc1_high_q     <= 2'd0;
      mbc1_ram_mode_q <= 1'b0;
      rom_bank_q      <= 9'd1;
      mbc5_bank_q     <= 9'd1;
      ram_bank_q      <= 4'd0;
    end else begin
      ram_en_q        <= ram_en_d;
      mbc1_low_q      <= mbc1_low_d;
      mbc1_high_q     <= mbc1_high_d;
      mbc1_ram_mode_q <= mbc1_ram_mode_d;
      rom_bank_q      <= rom_bank_d;
      mbc5_bank_q     <= mbc5_bank_d;
      ram_bank_q      <= ram_bank_d;
    end
  end

  // Result register: advance on accept, drop valid once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (accept) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      target_q   <= target_d;
      rom_addr_q <= rom_addr_d;
      ram_addr_q <= ram_addr_d;
      ram_data_q <= ram_data_d;
      high_nib_q <= high_nib_d;
    end
  end

  assign rsp_o.valid             = rsp_valid_q;
  assign rsp_o.target            = target_q;
  assign rsp_o.rom_address       = rom_addr_q;
  assign rsp_o.ram_address       = ram_addr_q;
  assign rsp_o.ram_data          = ram_data_q;
  assign rsp_o.force_high_nibble = high_nib_q;

  // A waiting result is never overwritten by a new transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && !rsp_o.ready) |-> !accept)
    else $error("result overwritten while stalled");

  // MBC1 low bank can never hold zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mbc1_low_q != 5'd0)
    else $error("mbc1 low bank is zero");

  // High nibble forcing only on RAM reads
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && high_nib_q) |-> (target_q == TGT_RAM_READ))
    else $error("high nibble forced outside a ram read");

  // An accepted ROM-region write yields a control result next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_write && !addr[15]) |=> (rsp_valid_q && target_q == TGT_CONTROL))
    else $error("control write not reported");

endmodule
